>>> design/whole_word_replace_stream_defines.svh
// Assertion macros shared by the whole-word replace stream modules.
`ifndef WHOLE_WORD_REPLACE_STREAM_DEFINES_SVH
`define WHOLE_WORD_REPLACE_STREAM_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define WWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define WWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/wwr_pkg.sv
// Types, constants and helpers shared by the whole-word replace stream modules.
package wwr_pkg;

  localparam logic [7:0] SpaceChar = 8'd32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    CfgFindWord    = 2'd0,
    CfgFindLen     = 2'd1,
    CfgReplaceWord = 2'd2,
    CfgReplaceLen  = 2'd3
  } cfg_idx_e;

  // One emit job: cnt bytes of word, then optionally the tail byte.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic [7:0]  tail;
    logic        has_tail;
    logic        last;
  } wwr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wwr_q_status_t;

  function automatic logic [3:0] sat_len(input logic [3:0] v, input logic [3:0] lim);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/wwr_front.sv
// Front end: takes input bytes, keeps the pending word and issues emit jobs.
`include "whole_word_replace_stream_defines.svh"

module wwr_front #(
  parameter int unsigned MaxWord = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  input  logic [63:0]      find_word_i,
  input  logic [3:0]       find_len_i,
  input  logic [63:0]      replace_word_i,
  input  logic [3:0]       replace_len_i,
  output logic             push_o,
  output wwr_pkg::wwr_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(MaxWord + 1);
  localparam int unsigned IdxW = (MaxWord > 1) ? $clog2(MaxWord) : 1;

  logic [7:0]      buf_q [MaxWord];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pass_q, pass_d;

  logic            accept;
  logic            is_space, fits, sel_app, buf_we, diff, match;
  logic [CntW-1:0] flen, cnt_inc, res_cnt;
  logic [3:0]      rlen;
  logic [63:0]     word_cur, word_app, res_word, resolve_word;
  logic [3:0]      resolve_cnt;
  wwr_pkg::wwr_cmd_t cmd;

  assign accept   = in_valid_i && !q_full_i;
  assign flen     = CntW'(wwr_pkg::sat_len(find_len_i, 4'(MaxWord)));
  assign rlen     = wwr_pkg::sat_len(replace_len_i, 4'(MaxWord));
  assign is_space = (in_byte_i == wwr_pkg::SpaceChar);
  assign fits     = (cnt_q < flen);
  assign cnt_inc  = cnt_q + 1'b1;
  assign sel_app  = !is_space && !pass_q && fits && in_last_i;
  assign res_word = sel_app ? word_app : word_cur;
  assign res_cnt  = sel_app ? cnt_inc : cnt_q;

  always_comb begin
    word_cur = '0;
    word_app = '0;
    diff     = 1'b0;
    for (int i = 0; i < MaxWord; i++) begin
      word_cur[i*8 +: 8] = buf_q[i];
      word_app[i*8 +: 8] = (CntW'(i) == cnt_q) ? in_byte_i : buf_q[i];
    end
    for (int i = 0; i < MaxWord; i++) begin
      if ((CntW'(i) < flen) && (res_word[i*8 +: 8] != find_word_i[i*8 +: 8])) begin
        diff = 1'b1;
      end
    end
  end

  assign match        = (res_cnt == flen) && !diff;
  assign resolve_word = match ? replace_word_i : res_word;
  assign resolve_cnt  = match ? rlen : 4'(res_cnt);

  always_comb begin
    cmd    = '0;
    cnt_d  = cnt_q;
    pass_d = pass_q;
    buf_we = 1'b0;
    if (is_space) begin
      if (!pass_q) begin
        cmd.word = resolve_word;
        cmd.cnt  = resolve_cnt;
      end
      cmd.tail     = in_byte_i;
      cmd.has_tail = 1'b1;
      cnt_d        = '0;
      pass_d       = 1'b0;
    end else if (pass_q) begin
      cmd.tail     = in_byte_i;
      cmd.has_tail = 1'b1;
    end else if (fits) begin
      buf_we = 1'b1;
      cnt_d  = cnt_inc;
      if (in_last_i) begin
        cmd.word = resolve_word;
        cmd.cnt  = resolve_cnt;
      end
    end else begin
      cmd.word     = word_cur;
      cmd.cnt      = 4'(cnt_q);
      cmd.tail     = in_byte_i;
      cmd.has_tail = 1'b1;
      cnt_d        = '0;
      pass_d       = 1'b1;
    end
    if (in_last_i) begin
      cmd.last = 1'b1;
      cnt_d    = '0;
      pass_d   = 1'b0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.cnt != 4'd0) || cmd.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pass_q <= 1'b0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && buf_we) begin
      buf_q[cnt_q[IdxW-1:0]] <= in_byte_i;
    end
  end

  `WWR_ASSERT_NEXT(a_line_end_clears, accept && in_last_i, (cnt_q == '0) && !pass_q, "word state not cleared after line end")
  `WWR_ASSERT(a_cnt_bounded, cnt_q <= flen || pass_q || cnt_q <= CntW'(MaxWord), "pending word longer than buffer")

endmodule

>>> design/wwr_queue.sv
// Short queue of emit jobs between the front end and the output side.
`include "whole_word_replace_stream_defines.svh"

module wwr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wwr_pkg::wwr_cmd_t     data_i,
  input  logic                  pop_i,
  output wwr_pkg::wwr_cmd_t     data_o,
  output wwr_pkg::wwr_q_status_t status_o
);

  wwr_pkg::wwr_cmd_t           mem_q [wwr_pkg::QueueDepth];
  logic [wwr_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [wwr_pkg::QPtrW:0]     fill_q;
  logic                        full, empty;

  assign full            = (fill_q == (wwr_pkg::QPtrW + 1)'(wwr_pkg::QueueDepth));
  assign empty           = (fill_q == '0);
  assign status_o.full   = full;
  assign status_o.empty  = empty;
  assign data_o          = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `WWR_ASSERT(a_no_overflow, !(push_i && full), "push into full queue")
  `WWR_ASSERT(a_no_underflow, !(pop_i && empty), "pop from empty queue")

endmodule

>>> design/wwr_back.sv
// Output side: plays each emit job out one byte per cycle while the receiver is ready.
`include "whole_word_replace_stream_defines.svh"

module wwr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wwr_pkg::wwr_cmd_t      q_data_i,
  input  wwr_pkg::wwr_q_status_t q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o
);

  wwr_pkg::wwr_cmd_t cmd_q;
  logic              valid_q;
  logic [3:0]        pos_q;
  logic [3:0]        total;
  logic              final_byte, take, load;

  assign total       = cmd_q.cnt + {3'b000, cmd_q.has_tail};
  assign final_byte  = (pos_q == total - 4'd1);
  assign take        = valid_q && out_ready_i;
  assign load        = (!valid_q || (take && final_byte)) && !q_status_i.empty;
  assign pop_o       = load;

  assign out_valid_o = valid_q;
  assign out_byte_o  = (pos_q < cmd_q.cnt) ? cmd_q.word[{pos_q[2:0], 3'b000} +: 8] : cmd_q.tail;
  assign out_last_o  = cmd_q.last && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      pos_q   <= '0;
    end else if (take) begin
      if (final_byte) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_data_i;
    end
  end

  `WWR_ASSERT(a_pos_in_range, !valid_q || (pos_q < total), "byte position beyond end of job")
  `WWR_ASSERT_NEXT(a_hold_on_stall, valid_q && !out_ready_i, valid_q && $stable(pos_q), "job lost while stalled")

endmodule

>>> design/whole_word_replace_stream.sv
// Top level of the whole-word find and replace byte stream.
//
// Bytes of a line enter on the s_axis channel, s_axis_tlast set on the line's final byte.
// The rewritten line leaves on m_axis, with m_axis_tlast on its final byte.
// Every whole word, delimited by spaces and the line ends, that equals the find word
// is replaced by the replacement word. Find and replacement words and their lengths are
// written through the cfg port (index 0 find word, 1 find length, 2 replacement word,
// 3 replacement length) while the block is idle.
// Output bytes go through the job queue and the output stage. A word is held back until
// its closing space, the line end or a letter past the find length. Throughput: one
// input item per cycle while the output keeps pace; the single output port moves one
// byte per cycle while the receiver is ready, so the end of a word may emit up to
// MaxWord plus one bytes in a burst, absorbed by a four-job queue between front end and
// output side. When the receiver stalls, the output byte holds, the queue fills and
// s_axis_tready drops; no item is lost. Reset clears the word state, the queue and the
// output stage and sets the find and replacement lengths to one and their words to zero.
module whole_word_replace_stream #(
  parameter int unsigned MaxWord = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] find_word_q, replace_word_q;
  logic [3:0]  find_len_q, replace_len_q;

  logic                   push, pop;
  wwr_pkg::wwr_cmd_t      push_cmd, pop_cmd;
  wwr_pkg::wwr_q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_word_q    <= '0;
      find_len_q     <= 4'd1;
      replace_word_q <= '0;
      replace_len_q  <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (wwr_pkg::cfg_idx_e'(cfg_idx_i))
        wwr_pkg::CfgFindWord:    find_word_q    <= cfg_data_i;
        wwr_pkg::CfgFindLen:     find_len_q     <= cfg_data_i[3:0];
        wwr_pkg::CfgReplaceWord: replace_word_q <= cfg_data_i;
        wwr_pkg::CfgReplaceLen:  replace_len_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_status.full;

  wwr_front #(
    .MaxWord(MaxWord)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_byte_i      (s_axis_tdata),
    .in_last_i      (s_axis_tlast),
    .q_full_i       (q_status.full),
    .find_word_i    (find_word_q),
    .find_len_i     (find_len_q),
    .replace_word_i (replace_word_q),
    .replace_len_i  (replace_len_q),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  wwr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (pop),
    .data_o   (pop_cmd),
    .status_o (q_status)
  );

  wwr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the whole-word replace stream, with a predictor and random text.
module tb;

  localparam logic [3:0] MAX_WORD = 4'd8;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [7:0] out_byte
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [63:0] cfg_data_i = 64'd0;

  logic [63:0] find_word_r = 64'd0;
  logic [3:0]  find_len_r = 4'd1;
  logic [63:0] replace_word_r = 64'd0;
  logic [3:0]  replace_len_r = 4'd1;

  logic [7:0]  word_buf [MAX_WORD];
  logic [3:0]  word_len = 4'd0;
  logic        passing = 1'b0;

  char_t       line_chars_q [$];
  char_t       text_out_q [$];
  char_t       exp_c;
  char_t       drv_c;

  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  logic        idle_on = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned stall_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned chars_taken = 0;
  int unsigned chars_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned err_count = 0;

  whole_word_replace_stream #(
    .MaxWord(8)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [3:0] clamp_len(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > MAX_WORD) return MAX_WORD;
    return v;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    if (r == wwr_pkg::SpaceChar) r = 8'h21;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic emit_char(input logic [7:0] c);
    text_out_q.push_back('{ch: c, eol: 1'b0});
  endtask

  task automatic close_word();
    logic [3:0] fl;
    logic [3:0] rl;
    logic       hit;
    fl = clamp_len(find_len_r);
    rl = clamp_len(replace_len_r);
    hit = (word_len == fl);
    for (int i = 0; hit && i < fl; i++) begin
      if (word_buf[i] != find_word_r[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      for (int i = 0; i < rl; i++) emit_char(replace_word_r[8*i +: 8]);
    end else begin
      for (int i = 0; i < word_len; i++) emit_char(word_buf[i]);
    end
    word_len = 4'd0;
  endtask

  // Updates the word state for one accepted character and queues the characters it releases.
  task automatic rewrite_char(input logic [7:0] c, input logic lst);
    int         start;
    logic [3:0] fl;
    start = text_out_q.size();
    fl = clamp_len(find_len_r);
    if (c == wwr_pkg::SpaceChar) begin
      if (!passing) close_word();
      passing = 1'b0;
      word_len = 4'd0;
      emit_char(c);
    end else if (passing) begin
      emit_char(c);
    end else if (word_len < fl) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      for (int i = 0; i < word_len; i++) emit_char(word_buf[i]);
      emit_char(c);
      word_len = 4'd0;
      passing = 1'b1;
    end
    if (lst) begin
      if (!passing && word_len > 0) close_word();
      passing = 1'b0;
      word_len = 4'd0;
      if (text_out_q.size() > start) text_out_q[text_out_q.size() - 1].eol = 1'b1;
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic lst);
    line_chars_q.push_back('{ch: c, eol: lst});
    chars_sent++;
  endtask

  task automatic push_text(input string s, input logic lst);
    for (int i = 0; i < s.len(); i++) push_char(s[i], lst && (i == s.len() - 1));
  endtask

  task automatic write_reg(input wwr_pkg::cfg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      wwr_pkg::CfgFindWord: find_word_r = val;
      wwr_pkg::CfgFindLen: find_len_r = val[3:0];
      wwr_pkg::CfgReplaceWord: replace_word_r = val;
      wwr_pkg::CfgReplaceLen: replace_len_r = val[3:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (chars_taken != chars_sent || text_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Builds one line mostly from copies and near misses of the find word.
  task automatic add_random_line();
    logic [7:0] txt [$];
    logic [3:0] fl;
    int         ntok;
    int         shape;
    int         n;
    fl = clamp_len(find_len_r);
    ntok = $urandom_range(1, 5);
    if ($urandom_range(0, 5) == 0) txt.push_back(wwr_pkg::SpaceChar);
    for (int k = 0; k < ntok; k++) begin
      if (k > 0) begin
        txt.push_back(wwr_pkg::SpaceChar);
        if ($urandom_range(0, 7) == 0) txt.push_back(wwr_pkg::SpaceChar);
      end
      shape = $urandom_range(0, 9);
      if (shape <= 3) begin
        for (int j = 0; j < fl; j++) txt.push_back(find_word_r[8*j +: 8]);
      end else if (shape == 4) begin
        n = (fl > 1) ? $urandom_range(1, fl - 1) : 1;
        for (int j = 0; j < n; j++) begin
          txt.push_back((fl > 1) ? find_word_r[8*j +: 8] : rand_letter());
        end
      end else if (shape == 5) begin
        n = $urandom_range(0, fl - 1);
        for (int j = 0; j < fl; j++) begin
          txt.push_back((j == n) ? rand_letter() : find_word_r[8*j +: 8]);
        end
      end else if (shape == 6) begin
        for (int j = 0; j < fl; j++) txt.push_back(find_word_r[8*j +: 8]);
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++) txt.push_back(rand_letter());
      end else begin
        n = $urandom_range(1, 10);
        for (int j = 0; j < n; j++) txt.push_back(rand_letter());
      end
    end
    if ($urandom_range(0, 5) == 0) txt.push_back(wwr_pkg::SpaceChar);
    for (int i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_acc)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (line_chars_q.size() > 0) begin
        drv_c = line_chars_q.pop_front();
        s_axis_tdata <= drv_c.ch;
        s_axis_tlast <= drv_c.eol;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        sink_hold = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    in_acc = 1'b0;
    out_acc = 1'b0;
    if (rst_ni) begin
      in_acc = s_axis_tvalid && s_axis_tready;
      out_acc = m_axis_tvalid && m_axis_tready;
      if (in_acc) begin
        rewrite_char(s_axis_tdata, s_axis_tlast);
        chars_taken++;
      end
      if (out_acc) begin
        chars_checked++;
        if (text_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          exp_c = text_out_q.pop_front();
          if (m_axis_tdata !== exp_c.ch) begin
            report_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata, exp_c.ch));
          end
          if (m_axis_tlast !== exp_c.eol) begin
            report_mismatch($sformatf("out_last %b, expected %b", m_axis_tlast, exp_c.eol));
          end
        end
      end
      if (in_acc || out_acc) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
                   STALL_LIMIT, text_out_q.size());
          $display("tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [63:0] val;
    logic [7:0]  b;
    int unsigned target;
    for (int i = 0; i < MAX_WORD; i++) word_buf[i] = 8'd0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // With the reset settings the find word is a single zero byte.
    push_char(8'h00, 1'b1);
    wait_idle();

    write_reg(wwr_pkg::CfgFindWord, 64'h0000_0000_0074_6163);
    write_reg(wwr_pkg::CfgFindLen, 64'd3);
    write_reg(wwr_pkg::CfgReplaceWord, 64'h7A79_7821_7367_6F64);
    write_reg(wwr_pkg::CfgReplaceLen, 64'd8);
    push_text(" cat  ca catt ", 1'b1);
    push_text("cat", 1'b1);
    push_text("cat", 1'b0);
    wait_idle();
    // The held word is now longer than the new find length, so the next letter flushes it.
    write_reg(wwr_pkg::CfgFindLen, 64'd2);
    push_char(8'hFF, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      for (int j = 0; j < 8; j++) begin
        b = rand_letter();
        if (p == 3 && j == 1) b = wwr_pkg::SpaceChar;
        val[8*j +: 8] = b;
      end
      write_reg(wwr_pkg::CfgFindWord, val);
      write_reg(wwr_pkg::CfgReplaceWord, {$urandom, $urandom});
      val = {$urandom, $urandom};
      case (p)
        0: val[3:0] = 4'd1;
        1: val[3:0] = 4'd8;
        2: val[3:0] = 4'd0;
        3: val[3:0] = 4'd15;
        4: val[3:0] = 4'($urandom_range(2, 7));
        default: val[3:0] = 4'($urandom_range(1, 8));
      endcase
      write_reg(wwr_pkg::CfgFindLen, val);
      val = {$urandom, $urandom};
      case (p)
        0: val[3:0] = 4'd8;
        1: val[3:0] = 4'd1;
        2: val[3:0] = 4'd15;
        3: val[3:0] = 4'd0;
        4: val[3:0] = 4'($urandom_range(1, 8));
        default: val[3:0] = 4'($urandom_range(2, 7));
      endcase
      write_reg(wwr_pkg::CfgReplaceLen, val);
      idle_on = (p != 5);
      target = chars_sent + 50;
      while (chars_sent < target) add_random_line();
      wait_idle();
    end

    $display("Sent %0d characters in lines built around the find word, %0d register writes.",
             chars_taken, reg_writes);
    $display("Checked %0d output characters, found %0d mismatches.", chars_checked, err_count);
    if (err_count == 0 && text_out_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/wwr_pkg.sv
design/wwr_front.sv
design/wwr_queue.sv
design/wwr_back.sv
design/whole_word_replace_stream.sv
sim/tb.sv
